>>> rtl/rgbpi_pkg.sv
// ----------------------------------------------------------------------------
// rgbpi_pkg
// Shared types, constants and helpers for the RGB555 palette indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbpi_pkg;

  localparam int unsigned PaletteDepthDef = 256;
  localparam int unsigned ColorW          = 15;
  localparam int unsigned CountW          = 9;
  localparam int unsigned IndexW          = 8;
  localparam int unsigned ChanInW         = 8;
  localparam int unsigned ChanW           = 5;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  // Per-cell status, only meaningful in the cell that holds the token
  typedef struct packed {
    logic hit;
    logic add;
  } cell_stat_t;

  // floor(c * 31 / 255); x / 255 == (x + 1 + (x >> 8)) >> 8 for x below 65535
  function automatic logic [ChanW-1:0] scale_chan(input logic [ChanInW-1:0] c);
    logic [12:0] prod;
    logic [13:0] sum;
    prod = {c, 5'd0} - {5'd0, c};
    sum  = {1'b0, prod} + 14'd1 + {8'd0, prod[12:8]};
    return sum[12:8];
  endfunction

endpackage

`default_nettype wire

>>> rtl/rgb555_palette_indexer.sv
// ----------------------------------------------------------------------------
// rgb555_palette_indexer
// Scales RGB888 pixels to RGB555 and assigns palette indices in order of
// first appearance, using a chain of compare cells.
// ----------------------------------------------------------------------------
// One pixel is handled at a time. On acceptance the packed color is
// registered for every palette cell to compare, and a search token walks the
// cell chain one cell per cycle. A pixel that hits at index k, or is appended
// at index k, frees the input once the token has resolved in cell k; a miss on
// a full palette frees it once the token has passed the last cell. The result
// is held in an output register, so the next pixel is accepted while a result
// still waits; the token walk pauses in every cycle in which the previous
// result is still offered and not taken. A pixel with new_image set empties
// the palette first and always gets index 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb555_palette_indexer
  import rgbpi_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               new_image_i,
  input  wire logic [ChanInW-1:0] red_in_i,
  input  wire logic [ChanInW-1:0] green_in_i,
  input  wire logic [ChanInW-1:0] blue_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [IndexW-1:0]       color_index_o,
  output logic [ColorW-1:0]       color_word_o,
  output logic                    added_entry_o,
  output logic                    palette_full_o,
  output logic [CountW-1:0]       entries_used_o
);

  localparam int unsigned PosW = $clog2(PALETTE_DEPTH);

  state_e            state_q, state_d;
  logic [ColorW-1:0] word_q;
  logic [CountW-1:0] count_q;
  logic [PosW-1:0]   pos_q;

  logic              out_valid_q;
  logic [IndexW-1:0] index_q;
  logic [ColorW-1:0] oword_q;
  logic              added_q;
  logic              full_q;
  logic [CountW-1:0] used_q;

  logic       start;
  logic       searching;
  logic       out_free;
  logic       advance;
  logic       finish;
  logic       hit_now;
  logic       add_now;
  logic       full_now;
  logic       resolved;
  cell_stat_t sel_stat;

  logic       fwd  [PALETTE_DEPTH];
  cell_stat_t stat [PALETTE_DEPTH];

  assign in_ready_o = (state_q == ST_IDLE);
  assign start      = in_valid_i & in_ready_o;
  assign searching  = (state_q == ST_SEARCH);
  assign out_free   = ~out_valid_q | out_ready_i;
  assign advance    = start | (searching & out_free);

  // Only the cell at pos_q can hold the token
  assign sel_stat = stat[pos_q];
  assign hit_now  = sel_stat.hit;
  assign add_now  = sel_stat.add;
  assign full_now = fwd[PALETTE_DEPTH-1];
  assign resolved = hit_now | add_now | full_now;
  assign finish   = searching & out_free & resolved;

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    logic tok_in;
    if (i == 0) begin : g_head
      assign tok_in = start;
    end else begin : g_link
      assign tok_in = fwd[i-1];
    end
    rgbpi_cell #(
      .Index(i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .advance_i(advance),
      .tok_i    (tok_in),
      .word_i   (word_q),
      .count_i  (count_q),
      .fwd_o    (fwd[i]),
      .stat_o   (stat[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (finish) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (start && new_image_i) begin
      count_q <= '0;
    end else if (finish && add_now) begin
      count_q <= count_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      word_q <= {scale_chan(blue_in_i), scale_chan(green_in_i), scale_chan(red_in_i)};
      pos_q  <= '0;
    end else if (searching && out_free && !resolved) begin
      pos_q  <= pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      index_q <= full_now ? '0 : IndexW'(pos_q);
      oword_q <= word_q;
      added_q <= add_now;
      full_q  <= full_now;
      used_q  <= add_now ? (count_q + CountW'(1)) : count_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign color_index_o  = index_q;
  assign color_word_o   = oword_q;
  assign added_entry_o  = added_q;
  assign palette_full_o = full_q;
  assign entries_used_o = used_q;

endmodule

`default_nettype wire

>>> rtl/rgbpi_cell.sv
// ----------------------------------------------------------------------------
// rgbpi_cell
// One palette slot: holds a color and passes the search token to its
// neighbor when the slot is in use and its color does not match.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpi_cell
  import rgbpi_pkg::*;
#(
  parameter int unsigned Index = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire logic              tok_i,
  input  wire logic [ColorW-1:0] word_i,
  input  wire logic [CountW-1:0] count_i,
  output logic                   fwd_o,
  output cell_stat_t             stat_o
);

  localparam logic [CountW-1:0] IdxC = CountW'(Index);

  logic              tok_q;
  logic [ColorW-1:0] entry_q;
  logic              at_end;
  logic              match;

  // The slot at the fill level is the first free one: a search reaching it misses
  assign at_end = (count_i == IdxC);
  assign match  = (entry_q == word_i);

  assign stat_o.hit = tok_q & ~at_end & match;
  assign stat_o.add = tok_q & at_end;
  assign fwd_o      = tok_q & ~at_end & ~match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
    end else if (advance_i) begin
      tok_q <= tok_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && tok_q && at_end) begin
      entry_q <= word_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rgbpi_checker.sv
// ----------------------------------------------------------------------------
// rgbpi_checker
// Port-level checks for the palette indexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rgbpi_checker
  import rgbpi_pkg::*;
#(
  parameter int unsigned PALETTE_DEPTH = PaletteDepthDef
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [IndexW-1:0]  color_index_o,
  input wire logic               added_entry_o,
  input wire logic               palette_full_o,
  input wire logic [CountW-1:0]  entries_used_o
);

  localparam logic [CountW-1:0] DepthC = CountW'(PALETTE_DEPTH);

  // A stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An accepted pixel leaves the input not ready in the next cycle
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transaction");

  a_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && palette_full_o |->
      !added_entry_o && color_index_o == '0 && entries_used_o == DepthC)
    else $error("overflow result inconsistent");

  a_add_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && added_entry_o |->
      entries_used_o != '0 && {1'b0, color_index_o} == entries_used_o - CountW'(1))
    else $error("appended index does not match fill level");

  a_hit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !added_entry_o && !palette_full_o |->
      {1'b0, color_index_o} < entries_used_o)
    else $error("hit index beyond fill level");

endmodule

bind rgb555_palette_indexer rgbpi_checker #(
  .PALETTE_DEPTH(PALETTE_DEPTH)
) u_rgbpi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .color_index_o (color_index_o),
  .added_entry_o (added_entry_o),
  .palette_full_o(palette_full_o),
  .entries_used_o(entries_used_o)
);

`default_nettype wire

>>> sim/tb_rgb555_palette_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb555_palette_indexer
// Self-checking bench for the RGB555 palette indexer. A clocked driver feeds
// pixels from a queue with random gaps, a clocked monitor takes results with
// random stalls. Each result is checked against a local model of the
// 5-5-5 scaling and the first-appearance palette, including clears and
// overflow on a full palette.
// ----------------------------------------------------------------------------

module tb_rgb555_palette_indexer;
  import rgbpi_pkg::*;

  localparam int unsigned PAL_DEPTH   = PaletteDepthDef;
  localparam int unsigned RAND_ITEMS  = 700;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned MAX_PRINTS  = 100;

  typedef enum int unsigned {
    IMG_SMALL,
    IMG_CONT,
    IMG_FILL,
    IMG_NOISE
  } img_kind_e;

  typedef struct {
    logic               new_image;
    logic [ChanInW-1:0] red;
    logic [ChanInW-1:0] green;
    logic [ChanInW-1:0] blue;
    bit                 drain;   // hold off until every result is back
  } pixel_t;

  typedef struct {
    logic [IndexW-1:0] index;
    logic [ColorW-1:0] word;
    logic              added;
    logic              full;
    logic [CountW-1:0] used;
  } lookup_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready_o;
  logic               new_image = 1'b0;
  logic [ChanInW-1:0] red_in = '0;
  logic [ChanInW-1:0] green_in = '0;
  logic [ChanInW-1:0] blue_in = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  logic [IndexW-1:0]  color_index;
  logic [ColorW-1:0]  color_word;
  logic               added_entry;
  logic               palette_full;
  logic [CountW-1:0]  entries_used;

  rgb555_palette_indexer #(
    .PALETTE_DEPTH(PAL_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .new_image_i   (new_image),
    .red_in_i      (red_in),
    .green_in_i    (green_in),
    .blue_in_i     (blue_in),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .color_index_o (color_index),
    .color_word_o  (color_word),
    .added_entry_o (added_entry),
    .palette_full_o(palette_full),
    .entries_used_o(entries_used)
  );

  pixel_t      pixel_q[$];
  lookup_t     lookup_q[$];
  pixel_t      cur_pix;

  logic [ColorW-1:0] pal_mem[PAL_DEPTH];
  int unsigned       pal_used = 0;

  int unsigned n_queued = 0;
  int unsigned n_images = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_hits = 0;
  int unsigned n_added = 0;
  int unsigned n_full = 0;
  int unsigned n_clears = 0;
  int unsigned stall_cycles = 0;

  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  int unsigned out_gap_n;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Palette model
  // --------------------------------------------------------------------------
  function automatic logic [ChanW-1:0] to_5bit(input logic [ChanInW-1:0] c);
    int unsigned p;
    p = c * 31;
    return ChanW'(p / 255);
  endfunction

  task automatic index_pixel(input pixel_t p);
    lookup_t           e;
    logic [ColorW-1:0] w;
    bit                hit;
    if (p.new_image) begin
      pal_used = 0;
      n_clears++;
    end
    w = {to_5bit(p.blue), to_5bit(p.green), to_5bit(p.red)};
    hit = 1'b0;
    e.index = '0;
    e.added = 1'b0;
    e.full  = 1'b0;
    for (int unsigned i = 0; i < pal_used; i++) begin
      if (!hit && pal_mem[i] == w) begin
        hit = 1'b1;
        e.index = IndexW'(i);
      end
    end
    if (hit) begin
      n_hits++;
    end else if (pal_used < PAL_DEPTH) begin
      e.index = IndexW'(pal_used);
      pal_mem[pal_used] = w;
      pal_used++;
      e.added = 1'b1;
      n_added++;
    end else begin
      e.full = 1'b1;
      n_full++;
    end
    e.word = w;
    e.used = CountW'(pal_used);
    lookup_q.insert(lookup_q.size(), e);
  endtask

  task automatic report_error(input string msg);
    if (n_errors < MAX_PRINTS) $display("[%0t] ERROR: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic check_lookup();
    lookup_t e;
    if (lookup_q.size() == 0) begin
      report_error($sformatf("unexpected transaction index=%0d word=%h",
                             color_index, color_word));
      return;
    end
    e = lookup_q.pop_front();
    if (color_index !== e.index)
      report_error($sformatf("result %0d color_index %0d, want %0d",
                             n_checked, color_index, e.index));
    if (color_word !== e.word)
      report_error($sformatf("result %0d color_word %h, want %h",
                             n_checked, color_word, e.word));
    if (added_entry !== e.added)
      report_error($sformatf("result %0d added_entry %b, want %b",
                             n_checked, added_entry, e.added));
    if (palette_full !== e.full)
      report_error($sformatf("result %0d palette_full %b, want %b",
                             n_checked, palette_full, e.full));
    if (entries_used !== e.used)
      report_error($sformatf("result %0d entries_used %0d, want %0d",
                             n_checked, entries_used, e.used));
    n_checked++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  task automatic queue_pixel(input logic ni, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input bit drain);
    pixel_t p;
    p.new_image = ni;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.drain = drain;
    pixel_q.insert(pixel_q.size(), p);
    n_queued++;
  endtask

  // Random 8-bit value that scales to the given 5-bit level
  function automatic logic [ChanInW-1:0] chan_raw(input int unsigned v);
    int unsigned lo;
    int unsigned hi;
    lo = (v * 255 + 30) / 31;
    hi = ((v + 1) * 255 + 30) / 31 - 1;
    if (hi > 255) hi = 255;
    return ChanInW'($urandom_range(hi, lo));
  endfunction

  task automatic queue_word(input logic ni, input logic [ColorW-1:0] w, input bit drain);
    queue_pixel(ni, chan_raw(32'(w[4:0])), chan_raw(32'(w[9:5])), chan_raw(32'(w[14:10])),
                drain);
  endtask

  function automatic logic [ColorW-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return ColorW'($urandom_range(0, 32767));
    endcase
  endfunction

  // Small color set with many repeats; cont skips the clear on the first pixel
  task automatic gen_small_image(input bit cont, input bit drain);
    logic [ColorW-1:0] word_set[24];
    int unsigned       n_set;
    int unsigned       len;
    n_set = $urandom_range(1, 24);
    len   = $urandom_range(8, 40);
    for (int unsigned s = 0; s < n_set; s++) word_set[s] = rand_word();
    for (int unsigned j = 0; j < len; j++) begin
      if ($urandom_range(0, 19) == 0)
        queue_pixel(j == 0 && !cont, 8'($urandom), 8'($urandom), 8'($urandom),
                    drain && j == 0);
      else
        queue_word(j == 0 && !cont, word_set[$urandom_range(0, n_set - 1)],
                   drain && j == 0);
    end
  endtask

  // Fills every palette entry, then mixes hits with misses on the full palette
  task automatic gen_fill_image(input bit drain);
    logic [ColorW-1:0] fill_w[PAL_DEPTH];
    int unsigned       base;
    int unsigned       stride;
    int unsigned       n_extra;
    base   = $urandom_range(0, 32767);
    stride = $urandom_range(0, 16383) * 2 + 1;
    for (int unsigned i = 0; i < PAL_DEPTH; i++) begin
      fill_w[i] = ColorW'(base + i * stride);
      queue_word(i == 0, fill_w[i], drain && i == 0);
      if (i > 0 && $urandom_range(0, 7) == 0)
        queue_word(1'b0, fill_w[$urandom_range(0, i)], 1'b0);
    end
    n_extra = $urandom_range(6, 16);
    for (int unsigned j = 0; j < n_extra; j++) begin
      if ($urandom_range(0, 1) == 0)
        queue_word(1'b0, fill_w[$urandom_range(0, PAL_DEPTH - 1)], 1'b0);
      else
        queue_word(1'b0, ColorW'(base + (PAL_DEPTH + j) * stride), 1'b0);
    end
  endtask

  task automatic gen_noise(input bit drain);
    int unsigned len;
    len = $urandom_range(4, 20);
    for (int unsigned j = 0; j < len; j++)
      queue_pixel($urandom_range(0, 7) == 0, 8'($urandom), 8'($urandom), 8'($urandom),
                  drain && j == 0);
  endtask

  task automatic gen_directed();
    queue_pixel(1'b1, 8'd0,   8'd0,   8'd0,   1'b0);  // first entry
    queue_pixel(1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(1'b0, 8'd8,   8'd8,   8'd8,   1'b0);  // scales to 0: hit
    queue_pixel(1'b0, 8'd255, 8'd0,   8'd0,   1'b0);
    queue_pixel(1'b0, 8'd0,   8'd255, 8'd0,   1'b0);
    queue_pixel(1'b0, 8'd0,   8'd0,   8'd255, 1'b0);
    queue_pixel(1'b0, 8'd254, 8'd255, 8'd255, 1'b0);
    queue_pixel(1'b0, 8'd9,   8'd9,   8'd9,   1'b0);
    queue_pixel(1'b0, 8'd250, 8'd250, 8'd250, 1'b0);
    queue_pixel(1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(1'b0, 8'hAA,  8'h55,  8'hAA,  1'b0);
    queue_pixel(1'b0, 8'h55,  8'hAA,  8'h55,  1'b0);
    queue_pixel(1'b0, 8'hAA,  8'h55,  8'hAA,  1'b0);
    queue_pixel(1'b1, 8'd255, 8'd255, 8'd255, 1'b0);  // clear, would have hit
    queue_pixel(1'b1, 8'd255, 8'd255, 8'd255, 1'b0);  // back-to-back clears
    queue_pixel(1'b0, 8'd0,   8'd0,   8'd0,   1'b0);
    queue_pixel(1'b0, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_pixel(1'b1, 8'd0,   8'd0,   8'd0,   1'b0);
    queue_pixel(1'b0, 8'h80,  8'h7F,  8'h01,  1'b0);
    queue_pixel(1'b0, 8'h01,  8'h80,  8'h7F,  1'b0);
  endtask

  task automatic gen_random();
    int unsigned limit;
    img_kind_e   kind;
    bit          drain;
    limit = n_queued + RAND_ITEMS;
    while (n_queued < limit) begin
      // first image fills the palette and waits for the directed results
      if (n_images == 0) begin
        kind = IMG_FILL;
      end else begin
        case ($urandom_range(0, 14))
          0:       kind = IMG_FILL;
          1, 2, 3: kind = IMG_CONT;
          4:       kind = IMG_NOISE;
          default: kind = IMG_SMALL;
        endcase
      end
      // a fill image near the end would overshoot the pixel budget
      if (kind == IMG_FILL && limit - n_queued < PAL_DEPTH + PAL_DEPTH / 2)
        kind = IMG_SMALL;
      drain = (n_images == 0) || ($urandom_range(0, 7) == 0);
      case (kind)
        IMG_FILL:  gen_fill_image(drain);
        IMG_CONT:  gen_small_image(1'b1, drain);
        IMG_NOISE: gen_noise(drain);
        default:   gen_small_image(1'b0, drain);
      endcase
      n_images++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      new_image <= 1'b0;
      red_in    <= '0;
      green_in  <= '0;
      blue_in   <= '0;
      in_gap    <= 0;
    end else begin
      if (in_valid && in_ready_o) begin
        index_pixel(cur_pix);
        n_accepted++;
      end
      if (!in_valid || in_ready_o) begin
        if (in_gap > 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (pixel_q.size() > 0 && !(pixel_q[0].drain && lookup_q.size() > 0)) begin
          cur_pix = pixel_q.pop_front();
          in_valid  <= 1'b1;
          new_image <= cur_pix.new_image;
          red_in    <= cur_pix.red;
          green_in  <= cur_pix.green;
          blue_in   <= cur_pix.blue;
          if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
          in_gap <= in_burst ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_gap   <= 0;
    end else begin
      out_gap_n = out_gap;
      if (out_valid_o && out_ready) begin
        check_lookup();
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_gap_n = out_burst ? 0 : $urandom_range(0, 3);
      end
      if (out_gap_n > 0) begin
        out_ready <= 1'b0;
        out_gap   <= out_gap_n - 1;
      end else begin
        out_ready <= 1'b1;
        out_gap   <= 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles without any transaction on either channel
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    gen_directed();
    gen_random();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixel_q.size() > 0 || in_valid) @(posedge clk_i);
    while (lookup_q.size() > 0) @(posedge clk_i);
    // a late extra result still gets caught by the monitor
    repeat (PAL_DEPTH + 8) @(posedge clk_i);

    $display("covered %0d pixels over %0d random images: %0d appended, %0d hits,",
             n_accepted, n_images, n_added, n_hits);
    $display("%0d full-palette misses, %0d clears; %0d results checked, %0d mismatches",
             n_full, n_clears, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> rgb555_palette_indexer.f
rtl/rgbpi_pkg.sv
rtl/rgbpi_cell.sv
rtl/rgb555_palette_indexer.sv
rtl/rgbpi_checker.sv
sim/tb_rgb555_palette_indexer.sv
